FILE: hw/rtl/pfa_pkg.sv
package pfa_pkg;

  // Default sizes of the frame table and of the swap area.
  localparam int unsigned FramesDef    = 256;
  localparam int unsigned SwapSlotsDef = 1024;

  // Bitmaps are kept in memory rows of this many bits.
  localparam int unsigned RowBits  = 32;
  localparam int unsigned RowShift = 5;

  localparam int unsigned FreeW = 9;
  localparam logic [FreeW-1:0] FreeSat = 9'd511;

  localparam logic [1:0] CmdAlloc   = 2'd0;
  localparam logic [1:0] CmdFree    = 2'd1;
  localparam logic [1:0] CmdRelease = 2'd2;

  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatAllPinned = 2'd1;
  localparam logic [1:0] StatSwapFull  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        pin;
    logic [31:0] owner_tag;
    logic [7:0]  frame_index;
    logic [9:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       granted_frame;
    logic             evicted;
    logic [31:0]      evicted_owner;
    logic [9:0]       swap_slot;
    logic [FreeW-1:0] free_frames;
  } out_t;

  typedef struct packed {
    logic                hit;
    logic [RowShift-1:0] pos;
  } first_t;

  // Lowest set bit of one bitmap row.
  function automatic first_t find_first(input logic [RowBits-1:0] bits);
    first_t r;
    r = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (bits[i]) begin
        r.hit = 1'b1;
        r.pos = RowShift'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/pfa_ram.sv
module pfa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pfa_outreg.sv
module pfa_outreg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pfa_pkg::out_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          stall_i,
  output pfa_pkg::out_t data_o
);
  import pfa_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  // The register can take a new result when it is empty or drained this cycle.
  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/page_frame_allocator_with_swap.sv
// Next-fit page frame allocator with eviction to swap slots. The frame valid
// and pin bitmaps, the swap slot bitmap and the owner tags live in synchronous
// memories; bitmaps are read one 32-bit row at a time, in a read state that
// addresses the row and a check state that searches it and writes it back. An
// allocation that finds a free frame visits 1 to ceil(FRAMES/32) + 1 rows, only
// one when the row at the pointer has room. An eviction searches rows for an
// unpinned frame and then rows for a free slot. Freeing a frame or releasing a
// slot works on a single row; an out-of-range index or an unused command goes
// straight to the result. A new transfer is taken as soon as the previous
// result sits in the output register. After reset the block clears its bitmaps
// row by row, max(ceil(FRAMES/32), ceil(SWAP_SLOTS/32)) rows (32 at the default
// sizes), and holds off input transfers meanwhile.
module page_frame_allocator_with_swap #(
  parameter int unsigned FRAMES     = pfa_pkg::FramesDef,
  parameter int unsigned SWAP_SLOTS = pfa_pkg::SwapSlotsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pfa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfa_pkg::out_t out_data_o
);
  import pfa_pkg::*;

  localparam int unsigned FidxW   = $clog2(FRAMES);
  localparam int unsigned FRows   = (FRAMES + RowBits - 1) / RowBits;
  localparam int unsigned FRowW   = (FRows > 1) ? $clog2(FRows) : 1;
  localparam int unsigned SidxW   = $clog2(SWAP_SLOTS);
  localparam int unsigned SRows   = (SWAP_SLOTS + RowBits - 1) / RowBits;
  localparam int unsigned SRowW   = (SRows > 1) ? $clog2(SRows) : 1;
  localparam int unsigned CntW    = $clog2(FRAMES + 1);
  localparam int unsigned ClrRows = (FRows > SRows) ? FRows : SRows;
  localparam int unsigned ClrW    = (ClrRows > 1) ? $clog2(ClrRows) : 1;

  localparam logic [RowBits-1:0] RowOnes = {RowBits{1'b1}};
  localparam logic [RowBits-1:0] RowOne  = RowBits'(1);
  localparam logic [RowBits-1:0] FLastMask = (FRAMES % RowBits == 0) ? RowOnes :
      RowBits'((64'd1 << (FRAMES % RowBits)) - 64'd1);
  localparam logic [RowBits-1:0] SLastMask = (SWAP_SLOTS % RowBits == 0) ? RowOnes :
      RowBits'((64'd1 << (SWAP_SLOTS % RowBits)) - 64'd1);

  typedef struct packed {
    logic [RowBits-1:0] pinned;
    logic [RowBits-1:0] valid;
  } fmap_t;

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0_0000_0000_0001,
    ST_IDLE   = 13'b0_0000_0000_0010,
    ST_FR_RD  = 13'b0_0000_0000_0100,
    ST_FR_CHK = 13'b0_0000_0000_1000,
    ST_VR_RD  = 13'b0_0000_0001_0000,
    ST_VR_CHK = 13'b0_0000_0010_0000,
    ST_SL_RD  = 13'b0_0000_0100_0000,
    ST_SL_CHK = 13'b0_0000_1000_0000,
    ST_FF_RD  = 13'b0_0001_0000_0000,
    ST_FF_CHK = 13'b0_0010_0000_0000,
    ST_RS_RD  = 13'b0_0100_0000_0000,
    ST_RS_CHK = 13'b0_1000_0000_0000,
    ST_DONE   = 13'b1_0000_0000_0000
  } state_e;

  state_e           state_q, state_d;
  in_t              req_q;
  out_t             res_q, res_d;
  logic [FRowW-1:0] frow_q, frow_d;
  logic [SRowW-1:0] srow_q, srow_d;
  logic             first_q, first_d;
  logic [FidxW-1:0] victim_q, victim_d;
  fmap_t            vword_q, vword_d;
  logic [FidxW-1:0] next_frame_q, next_frame_d;
  logic [CntW-1:0]  free_cnt_q, free_cnt_d;
  logic [ClrW-1:0]  clr_q, clr_d;

  logic               fm_we;
  logic [FRowW-1:0]   fm_waddr;
  fmap_t              fm_wdata, fm_rdata;
  logic               sl_we;
  logic [SRowW-1:0]   sl_waddr;
  logic [RowBits-1:0] sl_wdata, sl_rdata;
  logic               ow_we;
  logic [FidxW-1:0]   ow_waddr;
  logic [31:0]        ow_wdata, ow_rdata;

  logic               in_acc;
  logic               push, push_ready;
  out_t               push_data;

  logic [RowBits-1:0]  fr_mask, first_mask, fr_avail, vr_avail, sl_mask, sl_avail;
  logic [RowShift-1:0] nf_off, ff_off, rs_off, vic_off;
  first_t              fr_ff, vr_ff, sl_ff;
  logic [FidxW-1:0]    fr_frame;
  logic [SidxW-1:0]    sl_slot;
  logic [RowBits-1:0]  fr_bit, sl_bit, vic_bit, ff_bit, rs_bit;
  logic                ff_hit;
  logic [FreeW-1:0]    free_sat;

  // Memories: frame bitmaps, swap bitmap, owner tags.
  pfa_ram #(.Width($bits(fmap_t)), .Depth(FRows)) u_fmap (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (fm_wdata),
    .raddr_i (frow_q),
    .rdata_o (fm_rdata)
  );

  pfa_ram #(.Width(RowBits), .Depth(SRows)) u_smap (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .raddr_i (srow_q),
    .rdata_o (sl_rdata)
  );

  pfa_ram #(.Width(32), .Depth(FRAMES)) u_owner (
    .clk_i   (clk_i),
    .we_i    (ow_we),
    .waddr_i (ow_waddr),
    .wdata_i (ow_wdata),
    .raddr_i (victim_q),
    .rdata_o (ow_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Row search logic.
  assign nf_off     = RowShift'(next_frame_q);
  assign first_mask = RowOnes << nf_off;
  assign fr_mask    = (frow_q == FRowW'(FRows - 1)) ? FLastMask : RowOnes;
  assign fr_avail   = ~fm_rdata.valid & fr_mask & (first_q ? first_mask : RowOnes);
  assign vr_avail   = ~fm_rdata.pinned & fr_mask;
  assign fr_ff      = find_first(fr_avail);
  assign vr_ff      = find_first(vr_avail);
  assign fr_frame   = FidxW'({frow_q, fr_ff.pos});
  assign fr_bit     = RowOne << fr_ff.pos;

  assign sl_mask  = (srow_q == SRowW'(SRows - 1)) ? SLastMask : RowOnes;
  assign sl_avail = ~sl_rdata & sl_mask;
  assign sl_ff    = find_first(sl_avail);
  assign sl_slot  = SidxW'({srow_q, sl_ff.pos});
  assign sl_bit   = RowOne << sl_ff.pos;

  assign vic_off = RowShift'(victim_q);
  assign vic_bit = RowOne << vic_off;
  assign ff_off  = RowShift'(req_q.frame_index);
  assign ff_bit  = RowOne << ff_off;
  assign ff_hit  = fm_rdata.valid[ff_off];
  assign rs_off  = RowShift'(req_q.slot_index);
  assign rs_bit  = RowOne << rs_off;

  assign free_sat = (32'(free_cnt_q) > 32'(FreeSat)) ? FreeSat : FreeW'(free_cnt_q);

  always_comb begin
    push_data             = res_q;
    push_data.free_frames = free_sat;
  end

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    frow_d       = frow_q;
    srow_d       = srow_q;
    first_d      = first_q;
    victim_d     = victim_q;
    vword_d      = vword_q;
    next_frame_d = next_frame_q;
    free_cnt_d   = free_cnt_q;
    clr_d        = clr_q;
    fm_we        = 1'b0;
    fm_waddr     = frow_q;
    fm_wdata     = fm_rdata;
    sl_we        = 1'b0;
    sl_waddr     = srow_q;
    sl_wdata     = sl_rdata;
    ow_we        = 1'b0;
    ow_waddr     = victim_q;
    ow_wdata     = req_q.owner_tag;
    push         = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        fm_we    = (32'(clr_q) < FRows);
        fm_waddr = FRowW'(clr_q);
        fm_wdata = '0;
        sl_we    = (32'(clr_q) < SRows);
        sl_waddr = SRowW'(clr_q);
        sl_wdata = '0;
        if (clr_q == ClrW'(ClrRows - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ClrW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          case (in_data_i.cmd)
            CmdAlloc: begin
              if (free_cnt_q != '0) begin
                frow_d  = FRowW'(next_frame_q >> RowShift);
                first_d = 1'b1;
                state_d = ST_FR_RD;
              end else begin
                frow_d  = '0;
                state_d = ST_VR_RD;
              end
            end
            CmdFree: begin
              if (32'(in_data_i.frame_index) < FRAMES) begin
                frow_d  = FRowW'(in_data_i.frame_index >> RowShift);
                state_d = ST_FF_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            CmdRelease: begin
              if (32'(in_data_i.slot_index) < SWAP_SLOTS) begin
                srow_d  = SRowW'(in_data_i.slot_index >> RowShift);
                state_d = ST_RS_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_FR_RD: begin
        state_d = ST_FR_CHK;
      end
      ST_FR_CHK: begin
        if (fr_ff.hit) begin
          fm_we           = 1'b1;
          fm_wdata.valid  = fm_rdata.valid | fr_bit;
          fm_wdata.pinned = (fm_rdata.pinned & ~fr_bit) | (req_q.pin ? fr_bit : '0);
          ow_we           = 1'b1;
          ow_waddr        = fr_frame;
          next_frame_d    = (fr_frame == FidxW'(FRAMES - 1)) ? '0 : fr_frame + FidxW'(1);
          free_cnt_d      = free_cnt_q - CntW'(1);
          res_d.granted_frame = 8'(fr_frame);
          state_d         = ST_DONE;
        end else begin
          // The start row is visited twice: first from the pointer up, then whole.
          first_d = 1'b0;
          frow_d  = (frow_q == FRowW'(FRows - 1)) ? '0 : frow_q + FRowW'(1);
          state_d = ST_FR_RD;
        end
      end
      ST_VR_RD: begin
        state_d = ST_VR_CHK;
      end
      ST_VR_CHK: begin
        if (vr_ff.hit) begin
          victim_d = FidxW'({frow_q, vr_ff.pos});
          vword_d  = fm_rdata;
          srow_d   = '0;
          state_d  = ST_SL_RD;
        end else if (frow_q == FRowW'(FRows - 1)) begin
          res_d.status = StatAllPinned;
          state_d      = ST_DONE;
        end else begin
          frow_d  = frow_q + FRowW'(1);
          state_d = ST_VR_RD;
        end
      end
      ST_SL_RD: begin
        state_d = ST_SL_CHK;
      end
      ST_SL_CHK: begin
        if (sl_ff.hit) begin
          // The owner memory has been reading the victim since it was found,
          // so the old tag is read out here as the new one is written.
          sl_we           = 1'b1;
          sl_wdata        = sl_rdata | sl_bit;
          fm_we           = 1'b1;
          fm_wdata        = vword_q;
          fm_wdata.pinned = (vword_q.pinned & ~vic_bit) | (req_q.pin ? vic_bit : '0);
          ow_we           = 1'b1;
          res_d.evicted       = 1'b1;
          res_d.evicted_owner = ow_rdata;
          res_d.granted_frame = 8'(victim_q);
          res_d.swap_slot     = 10'(sl_slot);
          state_d         = ST_DONE;
        end else if (srow_q == SRowW'(SRows - 1)) begin
          res_d.status = StatSwapFull;
          state_d      = ST_DONE;
        end else begin
          srow_d  = srow_q + SRowW'(1);
          state_d = ST_SL_RD;
        end
      end
      ST_FF_RD: begin
        state_d = ST_FF_CHK;
      end
      ST_FF_CHK: begin
        if (ff_hit) begin
          fm_we           = 1'b1;
          fm_wdata.valid  = fm_rdata.valid & ~ff_bit;
          fm_wdata.pinned = fm_rdata.pinned & ~ff_bit;
          free_cnt_d      = free_cnt_q + CntW'(1);
        end
        state_d = ST_DONE;
      end
      ST_RS_RD: begin
        state_d = ST_RS_CHK;
      end
      ST_RS_CHK: begin
        sl_we    = 1'b1;
        sl_wdata = sl_rdata & ~rs_bit;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        push = 1'b1;
        if (push_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      frow_q       <= '0;
      srow_q       <= '0;
      first_q      <= 1'b0;
      next_frame_q <= '0;
      free_cnt_q   <= CntW'(FRAMES);
      clr_q        <= '0;
    end else begin
      state_q      <= state_d;
      frow_q       <= frow_d;
      srow_q       <= srow_d;
      first_q      <= first_d;
      next_frame_q <= next_frame_d;
      free_cnt_q   <= free_cnt_d;
      clr_q        <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    res_q    <= res_d;
    victim_q <= victim_d;
    vword_q  <= vword_d;
  end

  pfa_outreg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (push_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // A search that starts with free frames left must succeed by the time it
  // wraps back to the start row.
  a_free_search_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FR_CHK && !first_q && frow_q == FRowW'(next_frame_q >> RowShift))
      |-> fr_ff.hit)
    else $error("free frame search wrapped without a hit");

  // A result only enters the output register from the final state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result transfer appeared outside the final state");

  // Eviction only happens with every frame in use.
  a_evict_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SL_CHK && sl_ff.hit) |-> (free_cnt_q == '0))
    else $error("eviction while free frames remain");

  // Freeing a valid frame raises the free count by one.
  a_free_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FF_CHK && ff_hit) |=> (free_cnt_q == $past(free_cnt_q) + CntW'(1)))
    else $error("free count not updated on frame free");

endmodule
